// ----- hdl/aat_pkg.sv -----
// Shared types and constants for the activity aging table.
// No dependencies; imported by every module of the block.
`default_nettype none

package aat_pkg;

  localparam int unsigned PID_W    = 22;
  localparam int unsigned UID_W    = 31;
  localparam int unsigned REASON_W = 8;

  // Reset value of the minimum application user id register.
  localparam logic [UID_W-1:0] MIN_UID_RST = 31'd10000;

  typedef enum logic [1:0] {
    MODE_SEEN    = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  // Client key broadcast to every cell.
  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [UID_W-1:0] uid;
  } key_t;

  // One table entry as held by a cell.
  typedef struct packed {
    logic             valid;
    logic             seen;
    logic [PID_W-1:0] pid;
    logic [UID_W-1:0] uid;
  } entry_t;

endpackage

`default_nettype wire

// ----- hdl/aat_cell.sv -----
// One table entry of the aging ring: holds an entry and compares it to the key.
// Depends on aat_pkg.
`default_nettype none

module aat_cell
  import aat_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   shift_i,
  input  wire entry_t nxt_i,
  input  wire key_t   key_i,
  output entry_t      cur_o,
  output logic        match_o
);

  logic             valid_q, valid_d;
  logic             seen_q, seen_d;
  logic [PID_W-1:0] pid_q;
  logic [UID_W-1:0] uid_q;

  assign valid_d = shift_i ? nxt_i.valid : valid_q;
  assign seen_d  = shift_i ? nxt_i.seen : seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      seen_q  <= seen_d;
    end
  end

  // key storage, meaningful only while valid
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pid_q <= nxt_i.pid;
      uid_q <= nxt_i.uid;
    end
  end

  assign cur_o   = '{valid: valid_q, seen: seen_q, pid: pid_q, uid: uid_q};
  assign match_o = valid_q && (pid_q == key_i.pid) && (uid_q == key_i.uid);

endmodule

`default_nettype wire

// ----- hdl/aat_ctrl.sv -----
// Sequencer of the aging table: input beat, head-of-ring processing, result register.
// Depends on aat_pkg; drives the shift of the aat_cell ring.
`default_nettype none

module aat_ctrl
  import aat_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic [PID_W-1:0]    pid_i,
  input  wire logic [UID_W-1:0]    uid_i,
  input  wire logic [REASON_W-1:0] reason_code_i,
  input  wire logic [UID_W-1:0]    min_uid_i,
  // ring
  input  wire entry_t              head_i,
  input  wire logic [ENTRIES-1:0]  valid_vec_i,
  input  wire logic [ENTRIES-1:0]  seen_vec_i,
  input  wire logic [ENTRIES-1:0]  match_vec_i,
  output key_t                     key_o,
  output entry_t                   head_o,
  output logic                     shift_o,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [PID_W-1:0]         rep_pid_o,
  output logic [UID_W-1:0]         rep_uid_o,
  output logic                     is_active_o,
  output logic [REASON_W-1:0]      rep_reason_o,
  output logic                     dropped_o,
  output logic                     last_o
);

  localparam int unsigned SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [SW-1:0] LAST_STEP = SW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RUN
  } state_e;

  state_e          state_q;
  mode_e           mode_q;
  logic [SW-1:0]   step_q;
  logic [CW-1:0]   idle_cnt_q;
  logic            hit_q;
  logic            ins_q;
  logic            out_valid_q;
  key_t            key_q;
  logic [REASON_W-1:0] reason_q;

  mode_e         in_mode;
  logic          accept, start;
  logic          hit_any, unseen_hit, full, report;
  logic [CW-1:0] idle_cnt;
  logic          out_free, emit, shift, eval_go, ld_act, ld_idle, run;

  assign in_mode    = mode_e'(mode_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // ignored items (system users, unused code) finish in the accept cycle
  always_comb begin
    unique case (in_mode)
      MODE_SEEN:    start = (uid_i >= min_uid_i);
      MODE_TICK:    start = 1'b1;
      MODE_RESTART: start = 1'b1;
      default:      start = 1'b0;
    endcase
  end

  assign hit_any    = |match_vec_i;
  assign unseen_hit = |(match_vec_i & ~seen_vec_i);
  assign full       = &valid_vec_i;
  assign idle_cnt   = CW'($countones(valid_vec_i & ~seen_vec_i));
  assign report     = !hit_any || unseen_hit;

  assign out_free = !out_valid_q || !out_stall_i;
  assign run      = (state_q == ST_RUN);
  assign emit     = run && (mode_q == MODE_TICK) && head_i.valid && !head_i.seen;
  assign shift    = run && !(emit && !out_free);
  assign ld_idle  = emit && out_free;
  assign ld_act   = (state_q == ST_EVAL) && (mode_q == MODE_SEEN) && report && out_free;
  assign eval_go  = (state_q == ST_EVAL) &&
                    ((mode_q != MODE_SEEN) || !report || out_free);

  // head of ring, rewritten as it wraps to the tail
  always_comb begin
    head_o = head_i;
    case (mode_q)
      MODE_SEEN: begin
        if (hit_q && head_i.valid &&
            (head_i.pid == key_q.pid) && (head_i.uid == key_q.uid)) begin
          head_o.seen = 1'b1;
        end
        if (ins_q && !head_i.valid) begin
          head_o = '{valid: 1'b1, seen: 1'b1, pid: key_q.pid, uid: key_q.uid};
        end
      end
      MODE_TICK: begin
        if (head_i.valid) begin
          if (head_i.seen) begin
            head_o.seen = 1'b0;
          end else begin
            head_o.valid = 1'b0;
          end
        end
      end
      MODE_RESTART: begin
        head_o.seen = 1'b0;
      end
      default: ;
    endcase
  end

  assign shift_o = shift;
  assign key_o   = key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_SEEN;
      step_q      <= '0;
      idle_cnt_q  <= '0;
      hit_q       <= 1'b0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld_act || ld_idle) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && start) begin
            state_q <= ST_EVAL;
            mode_q  <= in_mode;
          end
        end
        ST_EVAL: begin
          if (eval_go) begin
            state_q    <= ST_RUN;
            step_q     <= '0;
            hit_q      <= hit_any;
            ins_q      <= !hit_any && !full;
            idle_cnt_q <= idle_cnt;
          end
        end
        ST_RUN: begin
          if (shift) begin
            step_q <= step_q + SW'(1);
            if (ins_q && !head_i.valid) begin
              ins_q <= 1'b0;
            end
            if (emit) begin
              idle_cnt_q <= idle_cnt_q - CW'(1);
            end
            if (step_q == LAST_STEP) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q    <= '{pid: pid_i, uid: uid_i};
      reason_q <= reason_code_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (ld_act) begin
      rep_pid_o    <= key_q.pid;
      rep_uid_o    <= key_q.uid;
      is_active_o  <= 1'b1;
      rep_reason_o <= reason_q;
      dropped_o    <= !hit_any && full;
      last_o       <= 1'b1;
    end else if (ld_idle) begin
      rep_pid_o    <= head_i.pid;
      rep_uid_o    <= head_i.uid;
      is_active_o  <= 1'b0;
      rep_reason_o <= '0;
      dropped_o    <= 1'b0;
      last_o       <= (idle_cnt_q == CW'(1));
    end
  end

  assign out_valid_o = out_valid_q;

  // a stored flag only ever sits on a valid entry
  a_seen_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_vec_i & ~valid_vec_i) == '0)
    else $error("seen flag on invalid entry");

  // idle report count never runs out before the sweep does
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_idle |-> (idle_cnt_q != '0))
    else $error("idle report without pending count");

  // at the end of a sweep every idle report has gone out
  a_cnt_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run && shift && (step_q == LAST_STEP) && (mode_q == MODE_TICK))
      |=> (idle_cnt_q == '0))
    else $error("sweep ended with idle reports outstanding");

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld_act || ld_idle) |-> out_free)
    else $error("result overwrote a pending beat");

endmodule

`default_nettype wire

// ----- hdl/activity_aging_table.sv -----
// Top level of the activity aging table: config register, ring of entry cells, sequencer.
// Depends on aat_pkg, aat_cell and aat_ctrl.
`default_nettype none

// Tracks active clients by (pid, uid) in a ring of ENTRIES cells. An activity
// beat (mode 0) from a uid at or above min_app_uid gives one active report
// unless the key is already stored with its seen flag set; a new key takes the
// lowest free entry, and a full table still reports with dropped set. A tick
// (mode 1) reports and removes each entry whose flag is clear, in ascending
// entry order, and clears the other flags; a restart (mode 2) clears all flags.
// Mode 3 and system-user activity beats are taken and dropped in their accept
// cycle. Every other beat passes the accept, an evaluate state and one full
// revolution of the ring, one entry per cycle while the ring is not held, before
// the next beat is taken. The evaluate state repeats while an active report
// waits on a stalled output, and the ring holds while a tick's idle report waits
// on a stalled output. Key matching, the free-entry check and the idle count run
// in parallel across the cells in the evaluate state. The last result of each
// beat carries last = 1. Write min_app_uid only while the block is idle.
module activity_aging_table
  import aat_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config write
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [UID_W-1:0]    cfg_data_i,
  // input beats
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic [PID_W-1:0]    pid_i,
  input  wire logic [UID_W-1:0]    uid_i,
  input  wire logic [REASON_W-1:0] reason_code_i,
  // result beats
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [PID_W-1:0]         rep_pid_o,
  output logic [UID_W-1:0]         rep_uid_o,
  output logic                     is_active_o,
  output logic [REASON_W-1:0]      rep_reason_o,
  output logic                     dropped_o,
  output logic                     last_o
);

  logic [UID_W-1:0]   min_uid_q;
  entry_t             cur   [ENTRIES];
  logic [ENTRIES-1:0] valid_vec, seen_vec, match_vec;
  entry_t             head_new;
  key_t               key;
  logic               shift;

  // single register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_uid_q <= MIN_UID_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_uid_q <= cfg_data_i;
    end
  end

  // Ring: cell 0 is the head seen by the sequencer; on each shift every cell
  // takes its upper neighbor and the last cell takes the rewritten head, so a
  // full revolution returns every entry to its own index.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t nxt;
    if (i == ENTRIES - 1) begin : g_tail
      assign nxt = head_new;
    end else begin : g_mid
      assign nxt = cur[i+1];
    end

    aat_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .nxt_i   (nxt),
      .key_i   (key),
      .cur_o   (cur[i]),
      .match_o (match_vec[i])
    );

    assign valid_vec[i] = cur[i].valid;
    assign seen_vec[i]  = cur[i].seen;
  end

  aat_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .pid_i         (pid_i),
    .uid_i         (uid_i),
    .reason_code_i (reason_code_i),
    .min_uid_i     (min_uid_q),
    .head_i        (cur[0]),
    .valid_vec_i   (valid_vec),
    .seen_vec_i    (seen_vec),
    .match_vec_i   (match_vec),
    .key_o         (key),
    .head_o        (head_new),
    .shift_o       (shift),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rep_pid_o     (rep_pid_o),
    .rep_uid_o     (rep_uid_o),
    .is_active_o   (is_active_o),
    .rep_reason_o  (rep_reason_o),
    .dropped_o     (dropped_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
